/* rtl/sorted_priority_queue_unit_defines.svh */
// Assertion macros used by the queue's port-level checker.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SPQ_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spq check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spq check failed");

`endif

/* rtl/spq_pkg.sv */
// Shared types, codes and field layout for the sorted priority queue.
package spq_pkg;

	localparam int unsigned CAPACITY_DEF = 16;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned PRIO_W = 16;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned FILL_W = 5;

	// request stream: tdata = {prio, data}, tuser = req_type
	localparam int unsigned IN_W  = DATA_W + PRIO_W;
	// result stream: tdata = {pad, fill, status, data}
	localparam int unsigned OUT_RAW_W = DATA_W + STAT_W + FILL_W;
	localparam int unsigned OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;
	localparam int unsigned OUT_PAD_W = OUT_W - OUT_RAW_W;

	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	localparam logic [DATA_W-1:0] NEG_ONE = '1;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic enq;
		logic deq;
	} spq_ctrl_t;

endpackage

/* rtl/sorted_priority_queue_unit.sv */
// Top level: bounded priority queue built as a shifting chain of sorted cells.
// The result is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle; every cell compares and shifts in parallel.
// A result held back by the receiver stalls the request channel until it is taken.
// Reset (arst_n low, async): queue empty, no result pending; slot contents are left as is.
module sorted_priority_queue_unit #(
	parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// request channel
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [spq_pkg::IN_W-1:0]  s_tdata,  // [31:0] item_data, [47:32] item_priority
	input  logic                      s_tuser,  // [0] req_type (0 enqueue, 1 dequeue)
	// result channel
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [spq_pkg::OUT_W-1:0] m_tdata   // [31:0] removed_data, [33:32] status,
	                                            // [38:34] fill_level, [39] zero
);
	import spq_pkg::*;

	// count must reach CAPACITY itself
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic [DATA_W-1:0] item_data;
	logic [PRIO_W-1:0] item_prio;
	logic              req_type;
	logic              take;
	logic              full;
	logic              empty;
	spq_ctrl_t         ctrl;

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_next;
	logic [STAT_W-1:0] status_c;
	logic [DATA_W-1:0] removed_c;

	logic [DATA_W-1:0] cell_data [CAPACITY];
	logic [PRIO_W-1:0] cell_prio [CAPACITY];
	logic              cell_le   [CAPACITY];

	logic              m_tvalid_q;
	logic [DATA_W-1:0] removed_q;
	logic [STAT_W-1:0] status_q;
	logic [FILL_W-1:0] fill_q;

	assign item_data = s_tdata[DATA_W-1:0];
	assign item_prio = s_tdata[DATA_W+PRIO_W-1:DATA_W];
	assign req_type  = s_tuser;

	// a new request may enter whenever the result slot is free or emptying
	assign s_tready = !m_tvalid_q || m_tready;
	assign take     = s_tvalid && s_tready;

	assign full  = count_q == CW'(CAPACITY);
	assign empty = count_q == '0;

	// full enqueue and empty dequeue leave the chain untouched
	assign ctrl.enq = take && (req_type == REQ_ENQ) && !full;
	assign ctrl.deq = take && (req_type == REQ_DEQ) && !empty;

	always_comb begin
		count_next = count_q;
		status_c   = ST_OK;
		removed_c  = NEG_ONE;
		if (req_type == REQ_ENQ) begin
			if (full) begin
				status_c = ST_FULL;
			end else begin
				count_next = count_q + CW'(1);
			end
		end else begin
			if (empty) begin
				status_c = ST_EMPTY;
			end else begin
				count_next = count_q - CW'(1);
				removed_c  = cell_data[0];   // head of chain holds smallest priority
			end
		end
	end

	// Cell chain. On enqueue each cell either keeps its entry, takes the new item
	// (first cell not ahead of it) or takes its left neighbour's entry. On dequeue
	// every cell takes its right neighbour's entry; the tail cell keeps its own.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic              l_le;
		logic [DATA_W-1:0] l_data;
		logic [PRIO_W-1:0] l_prio;
		logic [DATA_W-1:0] r_data;
		logic [PRIO_W-1:0] r_prio;

		if (i == 0) begin : g_head
			assign l_le   = 1'b1;
			assign l_data = item_data;
			assign l_prio = item_prio;
		end else begin : g_body
			assign l_le   = cell_le[i-1];
			assign l_data = cell_data[i-1];
			assign l_prio = cell_prio[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign r_data = cell_data[i];
			assign r_prio = cell_prio[i];
		end else begin : g_mid
			assign r_data = cell_data[i+1];
			assign r_prio = cell_prio[i+1];
		end

		spq_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.count      (count_q),
			.new_data   (item_data),
			.new_prio   (item_prio),
			.left_le    (l_le),
			.left_data  (l_data),
			.left_prio  (l_prio),
			.right_data (r_data),
			.right_prio (r_prio),
			.data       (cell_data[i]),
			.prio       (cell_prio[i]),
			.le         (cell_le[i])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q <= count_next;
			end
			if (take) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result payload; fill level is the count masked to the field
	always_ff @(posedge clk) begin
		if (take) begin
			removed_q <= removed_c;
			status_q  <= status_c;
			fill_q    <= FILL_W'(count_next);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, fill_q, status_q, removed_q};

endmodule

/* rtl/spq_cell.sv */
// One slot of the sorted chain: holds an entry and shifts with its neighbours.
module spq_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned CW  = 5
) (
	input  logic                       clk,
	input  spq_pkg::spq_ctrl_t         ctrl,
	input  logic [CW-1:0]              count,
	input  logic [spq_pkg::DATA_W-1:0] new_data,
	input  logic [spq_pkg::PRIO_W-1:0] new_prio,
	input  logic                       left_le,
	input  logic [spq_pkg::DATA_W-1:0] left_data,
	input  logic [spq_pkg::PRIO_W-1:0] left_prio,
	input  logic [spq_pkg::DATA_W-1:0] right_data,
	input  logic [spq_pkg::PRIO_W-1:0] right_prio,
	output logic [spq_pkg::DATA_W-1:0] data,
	output logic [spq_pkg::PRIO_W-1:0] prio,
	output logic                       le
);
	import spq_pkg::*;

	logic [DATA_W-1:0] data_q;
	logic [PRIO_W-1:0] prio_q;
	logic              occ;

	assign occ  = count > CW'(IDX);
	// entry stays ahead of the new item (ties keep arrival order)
	assign le   = occ && ($signed(prio_q) <= $signed(new_prio));
	assign data = data_q;
	assign prio = prio_q;

	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (!le) begin
				if (left_le) begin
					data_q <= new_data;
					prio_q <= new_prio;
				end else begin
					data_q <= left_data;
					prio_q <= left_prio;
				end
			end
		end else if (ctrl.deq) begin
			data_q <= right_data;
			prio_q <= right_prio;
		end
	end

endmodule

/* rtl/spq_chk.sv */
// Port-level checker for the queue, bound to the top level.
`include "sorted_priority_queue_unit_defines.svh"

module spq_chk #(
	parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [spq_pkg::OUT_W-1:0] m_tdata
);
	import spq_pkg::*;

	logic [STAT_W-1:0] st;
	logic [FILL_W-1:0] fill;

	assign st   = m_tdata[DATA_W+STAT_W-1:DATA_W];
	assign fill = m_tdata[DATA_W+STAT_W+FILL_W-1:DATA_W+STAT_W];

	// every accepted request yields a result next cycle
	`SPQ_ASSERT_NEXT(a_req_gives_result, s_tvalid && s_tready, m_tvalid)
	// stalled result is held
	`SPQ_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// empty dequeue only from an empty queue
	`SPQ_ASSERT_IMPL(a_empty_fill, m_tvalid && (st == ST_EMPTY), fill == '0)
	// dropped enqueue only from a full queue
	`SPQ_ASSERT_IMPL(a_full_fill, m_tvalid && (st == ST_FULL), fill == FILL_W'(CAPACITY))
	// no status code beyond the defined three
	`SPQ_ASSERT_IMPL(a_status_code, m_tvalid, (st == ST_OK) || (st == ST_EMPTY) || (st == ST_FULL))

endmodule

bind sorted_priority_queue_unit spq_chk #(
	.CAPACITY (CAPACITY)
) u_spq_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* tb/spq_result_checker.sv */
// Result checker for the sorted priority queue: tracks the queue contents and compares replies.
`timescale 1ns / 100ps

module spq_result_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [spq_pkg::IN_W-1:0]  s_tdata,   // [31:0] item_data, [47:32] item_priority
	input  logic                      s_tuser,   // [0] req_type
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [spq_pkg::OUT_W-1:0] m_tdata,   // [31:0] removed_data, [33:32] status,
	                                             // [38:34] fill_level, [39] zero
	output int                        fail_count,
	output int                        outstanding
);
	import spq_pkg::*;

	localparam int unsigned DEPTH = CAPACITY_DEF;

	typedef struct packed {
		logic [DATA_W-1:0] removed;
		logic [STAT_W-1:0] status;
		logic [FILL_W-1:0] fill;
	} reply_t;

	// shadow of the queue, front entry at index 0
	logic [DATA_W-1:0]        held_data [DEPTH];
	logic signed [PRIO_W-1:0] held_prio [DEPTH];
	int                       held_count = 0;

	reply_t due_replies [$];
	int     mismatches = 0;
	int     backlog    = 0;

	assign fail_count  = mismatches;
	assign outstanding = backlog;

	// Applies one request to the shadow queue and returns the reply it should give.
	function automatic reply_t apply_request(logic kind, logic [DATA_W-1:0] data,
	                                         logic signed [PRIO_W-1:0] prio);
		reply_t r;
		int     pos;
		r.removed = NEG_ONE;
		r.status  = ST_OK;
		if (kind == REQ_ENQ) begin
			if (held_count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// after every entry of lower or equal priority number
				pos = 0;
				while (pos < held_count && held_prio[pos] <= prio)
					pos++;
				for (int i = held_count; i > pos; i--) begin
					held_data[i] = held_data[i-1];
					held_prio[i] = held_prio[i-1];
				end
				held_data[pos] = data;
				held_prio[pos] = prio;
				held_count++;
			end
		end else begin
			if (held_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.removed = held_data[0];
				for (int i = 1; i < held_count; i++) begin
					held_data[i-1] = held_data[i];
					held_prio[i-1] = held_prio[i];
				end
				held_count--;
			end
		end
		r.fill = FILL_W'(held_count);
		return r;
	endfunction

	function automatic void check_field(string field, logic [DATA_W-1:0] want,
	                                    logic [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			held_count = 0;
			due_replies.delete();
		end else begin
			// replies first: a reply never belongs to a request taken in the same cycle
			if (m_tvalid && m_tready) begin
				if (due_replies.size() == 0) begin
					$display("%0t: reply with nothing outstanding, expected none, actual %h",
					         $time, m_tdata);
					mismatches++;
				end else begin
					want = due_replies.pop_front();
					check_field("removed_data", want.removed, m_tdata[DATA_W-1:0]);
					check_field("status", DATA_W'(want.status), DATA_W'(m_tdata[DATA_W +: STAT_W]));
					check_field("fill_level", DATA_W'(want.fill),
					            DATA_W'(m_tdata[DATA_W+STAT_W +: FILL_W]));
				end
			end
			if (s_tvalid && s_tready)
				due_replies.push_back(apply_request(s_tuser, s_tdata[DATA_W-1:0],
				                                    s_tdata[DATA_W +: PRIO_W]));
		end
		backlog = due_replies.size();
	end

endmodule

/* tb/tb_sorted_priority_queue_unit.sv */
// Testbench top for the sorted priority queue: clock, reset, request traffic and verdict.
`timescale 1ns / 100ps

module tb_sorted_priority_queue_unit;
	import spq_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;  // far beyond the slowest legal run
	localparam int HOLD_CYCLES  = 200;     // long receiver hold-off to back up the queue
	localparam int DRAIN_CYCLES = 8;       // covers the registered result, plus margin

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;       // [31:0] item_data, [47:32] item_priority
	logic             s_tuser  = REQ_ENQ;  // [0] req_type
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;             // [31:0] removed_data, [33:32] status,
	                                       // [38:34] fill_level, [39] zero

	int fail_count;
	int outstanding;

	// traffic shaping, percent of cycles
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// hold-off handshake between stimulus and the receiver process
	int holdoff_asks = 0;
	int holdoff_seen = 0;
	int holdoff_left = 0;

	int cycle_count = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sorted_priority_queue_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	spq_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// Receiver: random stalls, or a long hold-off when one is asked for.
	// The hold-off is counted here so the sender keeps pushing meanwhile.
	always @(posedge clk) begin
		if (holdoff_left != 0) begin
			m_tready     <= 1'b0;
			holdoff_left <= holdoff_left - 1;
		end else if (holdoff_seen != holdoff_asks) begin
			holdoff_seen <= holdoff_asks;
			holdoff_left <= HOLD_CYCLES - 1;
			m_tready     <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: a lost reply or a wedged handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Offers one request and returns once it has been taken.
	// Valid is only lowered when an idle cycle is actually inserted, so it
	// never gets two updates in the same step.
	task automatic offer_request(input logic kind, input logic [DATA_W-1:0] data,
	                             input logic [PRIO_W-1:0] prio);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {prio, data};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Priority spread: narrow bands give plenty of ties, the rest covers the
	// whole signed range and its edges.
	function automatic logic [PRIO_W-1:0] pick_priority();
		logic [PRIO_W-1:0] p;
		case ($urandom_range(3))
			0: begin
				p = PRIO_W'($urandom_range(3));
			end
			1: begin
				p = PRIO_W'($urandom_range(15)) - PRIO_W'(8);
			end
			2: begin
				case ($urandom_range(3))
					0:       p = 16'h8000;
					1:       p = 16'h7FFF;
					2:       p = 16'hFFFF;
					default: p = 16'h0000;
				endcase
			end
			default: begin
				p = PRIO_W'($urandom);
			end
		endcase
		return p;
	endfunction

	// Random traffic in bursts: filling bursts run the queue into full,
	// draining bursts run it dry, mixed ones churn the middle.
	task automatic random_traffic(input int count);
		int   sent;
		int   burst;
		int   enq_pct;
		logic kind;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(6, 40);
			if (burst > count - sent)
				burst = count - sent;
			case ($urandom_range(2))
				0:       enq_pct = 85;
				1:       enq_pct = 15;
				default: enq_pct = 50;
			endcase
			repeat (burst) begin
				kind = ($urandom_range(99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
				offer_request(kind, $urandom, pick_priority());
				sent++;
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed part ---
		// dequeue on an empty queue, unused fields all ones
		offer_request(REQ_DEQ, 32'hFFFF_FFFF, 16'hFFFF);
		offer_request(REQ_ENQ, 32'h0000_0000, 16'h0000);
		// new largest priority goes to the tail
		offer_request(REQ_ENQ, 32'h7FFF_FFFF, 16'h7FFF);
		// most negative priority goes to the front
		offer_request(REQ_ENQ, 32'h8000_0000, 16'h8000);
		// ties leave in arrival order
		offer_request(REQ_ENQ, 32'hFFFF_FFFF, 16'h0000);
		offer_request(REQ_ENQ, 32'h0000_0001, 16'h0000);
		offer_request(REQ_ENQ, 32'h0000_0002, 16'h7FFF);
		offer_request(REQ_ENQ, 32'h5555_5555, 16'hFFFF);
		offer_request(REQ_ENQ, 32'hAAAA_AAAA, 16'h0001);
		// top the queue up to capacity
		repeat (CAPACITY_DEF - 8)
			offer_request(REQ_ENQ, $urandom, pick_priority());
		// enqueue on a full queue is dropped
		offer_request(REQ_ENQ, 32'h1234_5678, 16'h8000);
		repeat (5)
			offer_request(REQ_DEQ, $urandom, PRIO_W'($urandom));

		// --- random part, one phase per traffic shape ---
		random_traffic(120);

		// long receiver hold-off while the sender keeps offering
		holdoff_asks <= holdoff_asks + 1;
		random_traffic(40);

		send_idle_pct  = 64;
		recv_stall_pct = 0;
		random_traffic(120);

		send_idle_pct  = 0;
		recv_stall_pct = 64;
		random_traffic(120);

		send_idle_pct  = 36;
		recv_stall_pct = 36;
		random_traffic(120);

		s_tvalid <= 1'b0;
		// sample the backlog away from the active edge
		do
			@(negedge clk);
		while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_unit.sv
rtl/spq_chk.sv
tb/spq_result_checker.sv
tb/tb_sorted_priority_queue_unit.sv
